FILE: rtl/rgst_pkg.sv
// Shared types and constants for the range gcd sparse table core.
`default_nettype none
package rgst_pkg;
    localparam int MaxElements = 1024;
    localparam int Levels      = 11;
    localparam int PosW        = 10;
    localparam int CntW        = 11;
    localparam int LvlW        = 4;
    localparam int ValW        = 63;
    localparam int Depth       = Levels * MaxElements;
    localparam int AddrW       = 14;
    localparam int BitCntW     = 7;

    localparam logic [1:0] FUNC_APPEND = 2'd0;
    localparam logic [1:0] FUNC_QUERY  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_LATCH_A,
        ST_LATCH_B,
        ST_GCD,
        ST_GCD_WAIT,
        ST_WRITE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
    } gcd_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } gcd_sts_t;
endpackage
`default_nettype wire

FILE: rtl/rgst_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module rgst_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] addr,
    input  wire logic [Width-1:0]         wdata,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

FILE: rtl/rgst_gcd.sv
// Bit-serial binary gcd: one subtract-or-shift step per cycle.
`default_nettype none
module rgst_gcd (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire rgst_pkg::gcd_ctl_t        ctl,
    input  wire logic [rgst_pkg::ValW-1:0] a,
    input  wire logic [rgst_pkg::ValW-1:0] b,
    output rgst_pkg::gcd_sts_t             sts,
    output logic [rgst_pkg::ValW-1:0]      result
);
    logic [rgst_pkg::ValW-1:0]    u_reg, u_next, v_reg, v_next;
    logic [rgst_pkg::BitCntW-1:0] sh_reg, sh_next;
    logic busy_reg, busy_next, done_reg, done_next;
    logic [rgst_pkg::ValW-1:0]    diff;

    assign diff = (u_reg > v_reg) ? u_reg - v_reg : v_reg - u_reg;

    always_comb
    begin
        u_next = u_reg;
        v_next = v_reg;
        sh_next = sh_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            u_next = a;
            v_next = b;
            sh_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (u_reg == '0 || v_reg == '0)
            begin
                // finish: the nonzero side, rescaled by common twos
                u_next = (u_reg | v_reg) << sh_reg;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (!u_reg[0] && !v_reg[0])
            begin
                u_next = u_reg >> 1;
                v_next = v_reg >> 1;
                sh_next = sh_reg + 1'b1;
            end
            else if (!u_reg[0])
            begin
                u_next = u_reg >> 1;
            end
            else if (!v_reg[0])
            begin
                v_next = v_reg >> 1;
            end
            else
            begin
                // both odd: keep the smaller, replace the larger by the half difference
                u_next = (u_reg < v_reg) ? u_reg : v_reg;
                v_next = diff >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg <= u_next;
        v_reg <= v_next;
        sh_reg <= sh_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign result = u_reg;
endmodule
`default_nettype wire

FILE: rtl/range_gcd_sparse_table_core.sv
// Top level of the range gcd sparse table core.
//
// Usage: one input stream (s_axis_*) carries commands. s_axis_tuser selects
// the command: append an element, query an inclusive one-indexed range, or
// clear the loaded elements. Only a query produces an output beat on
// m_axis_*, carrying the gcd of the range in tdata and a status flag in
// tuser (1 for an empty or out-of-range query).
// The table lives in one 11264 x 63 RAM with a registered read port.
// Commands are handled one at a time; s_axis_tready is high only when idle.
// An append runs one binary gcd per table level (up to 10). Each level reads
// two entries of the level below, runs the gcd and writes the result back.
// A query in range runs a single gcd before its output beat. A clear, an
// ignored append or an unused code is handled without leaving the idle state.
// The output beat is held in a register until m_axis_tready accepts it;
// the next command is taken only after the result leaves.
// Reset clears the element count and control state; table contents are
// undefined but never read before being written.
`default_nettype none
module range_gcd_sparse_table_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // bits: func[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    // bits: element_value[63:0], range_left[74:64], range_right[85:75], zero pad
    input  wire logic [87:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // bits: status[0]
    output logic             m_axis_tuser,
    // bits: range_gcd[62:0], zero pad
    output logic [63:0]      m_axis_tdata
);
    rgst_pkg::state_t state_reg, state_next;

    logic [rgst_pkg::CntW-1:0]  count_reg, count_next;
    logic [rgst_pkg::PosW-1:0]  pa_reg, pa_next, pb_reg, pb_next; // positions
    logic [rgst_pkg::LvlW-1:0]  lvl_reg, lvl_next;
    logic                       isq_reg, isq_next;
    logic [rgst_pkg::ValW-1:0]  ga_reg, ga_next, gb_reg, gb_next;
    logic [rgst_pkg::ValW-1:0]  res_reg, res_next;
    logic                       stat_reg, stat_next;

    logic                       we;
    logic [rgst_pkg::AddrW-1:0] addr;
    logic [rgst_pkg::ValW-1:0]  wdata, rdata;

    rgst_pkg::gcd_ctl_t gctl;
    rgst_pkg::gcd_sts_t gsts;
    logic [rgst_pkg::ValW-1:0] gres;

    logic [1:0]                 in_func;
    logic [63:0]                in_val;
    logic [rgst_pkg::CntW-1:0]  in_l, in_r;
    logic [63:0]                neg_val;
    logic [rgst_pkg::ValW-1:0]  mag;
    logic [rgst_pkg::CntW-1:0]  qlen;
    logic [rgst_pkg::LvlW-1:0]  qk;
    logic [rgst_pkg::CntW-1:0]  span;
    logic [rgst_pkg::CntW-1:0]  nxt_span;
    logic [rgst_pkg::CntW-1:0]  pos1;

    assign in_func = s_axis_tuser;
    assign in_val  = s_axis_tdata[63:0];
    assign in_l    = s_axis_tdata[74:64];
    assign in_r    = s_axis_tdata[85:75];
    assign neg_val = ~in_val + 64'd1;
    assign mag = !in_val[63] ? in_val[62:0]
               : (in_val == {1'b1, 63'd0}) ? {rgst_pkg::ValW{1'b1}} : neg_val[62:0];
    assign qlen = in_r - in_l + 11'd1;

    // floor(log2(len)) via priority search over 11 bits
    always_comb
    begin
        qk = '0;
        for (int i = 0; i < rgst_pkg::CntW; i++)
        begin
            if (qlen[i])
            begin
                qk = rgst_pkg::LvlW'(i);
            end
        end
    end

    assign span     = rgst_pkg::CntW'(1) << lvl_reg;
    assign nxt_span = span << 1;
    assign pos1     = count_reg + 11'd1; // one past appended position

    rgst_ram #(.Width(rgst_pkg::ValW), .Depth(rgst_pkg::Depth)) u_ram (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    rgst_gcd u_gcd (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (gctl),
        .a      (ga_reg),
        .b      (gb_reg),
        .sts    (gsts),
        .result (gres)
    );

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pa_next = pa_reg;
        pb_next = pb_reg;
        lvl_next = lvl_reg;
        isq_next = isq_reg;
        ga_next = ga_reg;
        gb_next = gb_reg;
        res_next = res_reg;
        stat_next = stat_reg;
        we = 1'b0;
        addr = {lvl_reg, pa_reg};
        wdata = res_reg;
        gctl.start = 1'b0;
        s_axis_tready = (state_reg == rgst_pkg::ST_IDLE);
        unique case (state_reg)
            rgst_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    unique case (in_func)
                        rgst_pkg::FUNC_APPEND:
                        begin
                            if (count_reg < 11'(rgst_pkg::MaxElements))
                            begin
                                // write level 0 now, then fold upward
                                we = 1'b1;
                                addr = {rgst_pkg::LvlW'(0), count_reg[rgst_pkg::PosW-1:0]};
                                wdata = mag;
                                lvl_next = rgst_pkg::LvlW'(1);
                                isq_next = 1'b0;
                                if (count_reg + 11'd1 < 11'd2)
                                begin
                                    count_next = count_reg + 11'd1;
                                end
                                else
                                begin
                                    // level 1 window: start = pos-1, halves pos-1, pos
                                    pa_next = count_reg[rgst_pkg::PosW-1:0] - 10'd1;
                                    pb_next = count_reg[rgst_pkg::PosW-1:0];
                                    state_next = rgst_pkg::ST_RD_A;
                                end
                            end
                        end
                        rgst_pkg::FUNC_QUERY:
                        begin
                            isq_next = 1'b1;
                            if (in_l == '0 || in_l > in_r || in_r > count_reg)
                            begin
                                res_next = '0;
                                stat_next = 1'b1;
                                state_next = rgst_pkg::ST_OUT;
                            end
                            else
                            begin
                                lvl_next = qk + rgst_pkg::LvlW'(1);
                                pa_next = 10'(in_l - 11'd1);
                                pb_next = 10'(in_r - (11'd1 << qk));
                                stat_next = 1'b0;
                                state_next = rgst_pkg::ST_RD_A;
                            end
                        end
                        rgst_pkg::FUNC_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            rgst_pkg::ST_RD_A:
            begin
                // read from level lvl-1
                addr = {lvl_reg - 4'd1, pa_reg};
                state_next = rgst_pkg::ST_RD_B;
            end
            rgst_pkg::ST_RD_B:
            begin
                addr = {lvl_reg - 4'd1, pb_reg};
                ga_next = rdata;
                state_next = rgst_pkg::ST_LATCH_B;
            end
            rgst_pkg::ST_LATCH_B:
            begin
                gb_next = rdata;
                state_next = rgst_pkg::ST_GCD;
            end
            rgst_pkg::ST_GCD:
            begin
                gctl.start = 1'b1;
                state_next = rgst_pkg::ST_GCD_WAIT;
            end
            rgst_pkg::ST_GCD_WAIT:
            begin
                if (gsts.done)
                begin
                    res_next = gres;
                    state_next = isq_reg ? rgst_pkg::ST_OUT : rgst_pkg::ST_WRITE;
                end
            end
            rgst_pkg::ST_WRITE:
            begin
                // store level lvl at start = pos+1-span
                we = 1'b1;
                addr = {lvl_reg, 10'(pos1 - span)};
                wdata = res_reg;
                if (lvl_reg == rgst_pkg::LvlW'(rgst_pkg::Levels - 1) || pos1 < nxt_span)
                begin
                    count_next = pos1;
                    state_next = rgst_pkg::ST_IDLE;
                end
                else
                begin
                    pa_next = 10'(pos1 - nxt_span);
                    pb_next = 10'(pos1 - span);
                    lvl_next = lvl_reg + 4'd1;
                    state_next = rgst_pkg::ST_RD_A;
                end
            end
            rgst_pkg::ST_OUT:
            begin
                if (m_axis_tready)
                begin
                    state_next = rgst_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rgst_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rgst_pkg::ST_IDLE;
            count_reg <= '0;
            isq_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            isq_reg <= isq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pa_reg <= pa_next;
        pb_reg <= pb_next;
        lvl_reg <= lvl_next;
        ga_reg <= ga_next;
        gb_reg <= gb_next;
        res_reg <= res_next;
        stat_reg <= stat_next;
    end

    assign m_axis_tvalid = (state_reg == rgst_pkg::ST_OUT);
    assign m_axis_tuser  = stat_reg;
    assign m_axis_tdata  = {1'b0, res_reg};

    // The element count never exceeds capacity.
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 11'(rgst_pkg::MaxElements))
        else $error("element count above capacity");

    // Input and output are never active together.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while result pending");

    // A rejected query carries a zero gcd.
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && stat_reg) |-> (res_reg == '0))
        else $error("bad query with nonzero gcd");
endmodule
`default_nettype wire
